/* design/clsr_pkg.sv */
// Shared constants, types and widths for the combined LCG shuffle generator.
// Used by clsr_mulmod and combined_lcg_shuffle_rng; depends on nothing.
package clsr_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned WARM_EXTRA  = 8;
  localparam int unsigned WARM_STEPS  = TABLE_DEPTH + WARM_EXTRA;

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = VAL_W + MUL_W;
  localparam int unsigned FOLD_W = 8;

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
  localparam int unsigned WARM_W = $clog2(WARM_STEPS);

  localparam logic [VAL_W-1:0] MOD_A        = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD_B        = 31'd2147483399;
  localparam logic [MUL_W-1:0] MUL_A        = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_B        = 16'd40692;
  localparam logic [VAL_W-1:0] SEED_B_RESET = 31'd123456789;
  localparam logic [VAL_W-1:0] SPAN         = MOD_A - 31'd1;

  // 2^31 is congruent to these values modulo each modulus
  localparam logic [FOLD_W-1:0] FOLD_A = FOLD_W'(32'h8000_0000 - 32'(MOD_A));
  localparam logic [FOLD_W-1:0] FOLD_B = FOLD_W'(32'h8000_0000 - 32'(MOD_B));

  localparam logic [VAL_W-1:0] SLOT_DIV =
    VAL_W'(64'd1 + 64'd2147483562 / 64'(TABLE_DEPTH));

  typedef struct packed {
    logic go;
    logic sel_b;
  } mm_req_t;

  typedef struct packed {
    logic done;
    logic sel_b;
  } mm_rsp_t;

endpackage

/* design/combined_lcg_shuffle_rng.sv */
// Top level of the combined two-generator random source with shuffle table.
// Depends on clsr_pkg and clsr_mulmod.
//
// Each input transfer gives exactly one output transfer. tuser carries the
// kind flag (0 = draw, 1 = reseed then draw), tdata bits 30:0 the seed. A
// draw runs through the states MULA, MULB, WAIT and MIX, and the next item
// can be taken as soon as its result is in the output register: a single
// shared multiply/reduce unit (two stages) advances the first and then the
// second generator, and the mix with the table entry follows. The slot index
// is found by comparing the output register against the fixed slot
// boundaries and is registered every cycle, off the draw's path. A reseed
// first runs TABLE_DEPTH + 8 warm-up steps through the same unit, each a
// WARM and a WWAIT state, before its draw. The block takes one item at a
// time; the output register lets the next item be accepted while the
// previous result waits, and a finished result is held back only if the
// earlier one has still not been taken. The shuffle table is a memory with
// one write port and one registered read port, plus per-entry valid flops,
// so an entry never written reads as zero straight after reset.
module combined_lcg_shuffle_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] seed_value, [31] zero
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [30:0] random_value, [31] zero
);
  import clsr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WARM  = 3'd1;
  localparam logic [2:0] ST_WWAIT = 3'd2;
  localparam logic [2:0] ST_MULA  = 3'd4;
  localparam logic [2:0] ST_MULB  = 3'd5;
  localparam logic [2:0] ST_WAIT  = 3'd6;
  localparam logic [2:0] ST_MIX   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [VAL_W-1:0]  gen_a_q, gen_a_d;
  logic [VAL_W-1:0]  gen_b_q, gen_b_d;
  logic [VAL_W-1:0]  last_q, last_d;
  logic [WARM_W-1:0] warm_q, warm_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_data_q, out_data_d;

  logic [VAL_W-1:0]       mem_q [TABLE_DEPTH];
  logic [VAL_W-1:0]       rd_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  mm_req_t          mm_req;
  mm_rsp_t          mm_rsp;
  logic [VAL_W-1:0] mm_x;
  logic [VAL_W-1:0] mm_res;

  logic              in_fire;
  logic [VAL_W-1:0]  seed;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  entry;
  logic [VAL_W+1:0]  diff;
  logic [VAL_W+1:0]  mixed;
  logic              mix_go;

  clsr_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .x_i    (mm_x),
    .rsp_o  (mm_rsp),
    .res_o  (mm_res)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign seed            = (s_axis_tdata_i[VAL_W-1:0] == '0) ? VAL_W'(1)
                                                             : s_axis_tdata_i[VAL_W-1:0];

  // slot index: the highest slot whose lower boundary the output register
  // reaches; stopping at the last slot gives the saturation
  always_comb begin
    slot_d = '0;
    for (int unsigned k = 1; k < TABLE_DEPTH; k++) begin
      if (64'(last_q) >= 64'(k) * 64'(SLOT_DIV)) begin
        slot_d = SLOT_W'(k);
      end
    end
  end

  // combine the selected entry with the second generator, wrap into range
  assign entry  = valid_q[slot_q] ? rd_q : '0;
  assign diff   = (VAL_W+2)'(entry) - (VAL_W+2)'(gen_b_q);
  assign mixed  = (diff[VAL_W+1] || (diff == '0)) ? diff + (VAL_W+2)'(SPAN) : diff;
  assign mix_go = (state_q == ST_MIX) && (!out_valid_q || m_axis_tready_i);

  // requests to the shared unit
  always_comb begin
    mm_req = '0;
    mm_x   = gen_a_q;
    unique case (state_q)
      ST_WARM: mm_req.go = 1'b1;
      ST_MULA: mm_req.go = 1'b1;
      ST_MULB: begin
        mm_req.go    = 1'b1;
        mm_req.sel_b = 1'b1;
        mm_x         = gen_b_q;
      end
      default: mm_req = '0;
    endcase
  end

  // table write port: warm-up fill or refill of the drawn slot
  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = gen_a_q;
    if ((state_q == ST_WWAIT) && mm_rsp.done && (warm_q < WARM_W'(TABLE_DEPTH))) begin
      we    = 1'b1;
      waddr = warm_q[SLOT_W-1:0];
      wdata = mm_res;
    end else if (mix_go) begin
      we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    gen_a_d     = gen_a_q;
    gen_b_d     = gen_b_q;
    last_d      = last_q;
    warm_d      = warm_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_data_d  = out_data_q;

    // take results from the shared unit as they come back
    if (mm_rsp.done) begin
      if (mm_rsp.sel_b) begin
        gen_b_d = mm_res;
      end else begin
        gen_a_d = mm_res;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i) begin
            gen_a_d = seed;
            gen_b_d = seed;
            warm_d  = WARM_W'(WARM_STEPS - 1);
            state_d = ST_WARM;
          end else begin
            state_d = ST_MULA;
          end
        end
      end
      ST_WARM: state_d = ST_WWAIT;
      ST_WWAIT: begin
        if (mm_rsp.done) begin
          if (warm_q == '0) begin
            // last warm-up value is slot zero and the new output register
            last_d  = mm_res;
            state_d = ST_MULA;
          end else begin
            warm_d  = warm_q - WARM_W'(1);
            state_d = ST_WARM;
          end
        end
      end
      ST_MULA: state_d = ST_MULB;
      ST_MULB: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mm_rsp.done && mm_rsp.sel_b) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        // hold until the previous result has left the output register
        if (mix_go) begin
          last_d      = mixed[VAL_W-1:0];
          out_data_d  = mixed[VAL_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_a_q     <= VAL_W'(1);
      gen_b_q     <= SEED_B_RESET;
      last_q      <= '0;
      warm_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      gen_a_q     <= gen_a_d;
      gen_b_q     <= gen_b_d;
      last_q      <= last_d;
      warm_q      <= warm_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  // shuffle table memory, registered read at the current slot
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[slot_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q};

`ifndef SYNTHESIS
  // the second generator only returns while its draw is waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done && mm_rsp.sel_b |-> state_q == ST_WAIT)
    else $error("second generator result outside its wait state");

  // a finished result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MIX && out_valid_q && !m_axis_tready_i |=> state_q == ST_MIX)
    else $error("result produced while output register still occupied");

  // every result lies in the generator range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q != '0 && out_data_q <= SPAN)
    else $error("result outside range");

  // a plain draw goes straight to the first generator step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !s_axis_tuser_i |=> state_q == ST_MULA)
    else $error("draw did not start with the first generator step");
`endif

endmodule

/* design/clsr_mulmod.sv */
// Shared two-stage multiply and modular reduction unit for both generators.
// Depends on clsr_pkg.
module clsr_mulmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  clsr_pkg::mm_req_t              req_i,
  input  logic [clsr_pkg::VAL_W-1:0]     x_i,
  output clsr_pkg::mm_rsp_t              rsp_o,
  output logic [clsr_pkg::VAL_W-1:0]     res_o
);
  import clsr_pkg::*;

  logic [PROD_W-1:0] prod_q, prod_d;
  logic              s1_valid_q, s1_sel_q;
  mm_rsp_t           rsp_q;
  logic [VAL_W-1:0]  res_q, res_d;

  logic [MUL_W-1:0]  mul_k;
  logic [FOLD_W-1:0] fold_k;
  logic [VAL_W-1:0]  mod_k;
  logic [VAL_W:0]    sum;

  // stage 1: exact product
  always_comb begin
    mul_k  = req_i.sel_b ? MUL_B : MUL_A;
    prod_d = PROD_W'(x_i) * PROD_W'(mul_k);
  end

  // stage 2: fold the high part back in, then one conditional subtract
  always_comb begin
    fold_k = s1_sel_q ? FOLD_B : FOLD_A;
    mod_k  = s1_sel_q ? MOD_B : MOD_A;
    sum    = (VAL_W+1)'(prod_q[VAL_W-1:0])
           + (VAL_W+1)'(prod_q[PROD_W-1:VAL_W]) * (VAL_W+1)'(fold_k);
    if (sum >= {1'b0, mod_k}) begin
      res_d = VAL_W'(sum - {1'b0, mod_k});
    end else begin
      res_d = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_sel_q   <= 1'b0;
      rsp_q      <= '0;
    end else begin
      s1_valid_q <= req_i.go;
      s1_sel_q   <= req_i.sel_b;
      rsp_q.done  <= s1_valid_q;
      rsp_q.sel_b <= s1_sel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign rsp_o = rsp_q;
  assign res_o = res_q;

endmodule

/* verif/tb_combined_lcg_shuffle_rng.sv */
// Self-checking testbench for combined_lcg_shuffle_rng: directed and random draws and reseeds
// checked against an in-bench model of the two generators and the shuffle table.
// Depends on clsr_pkg and the combined_lcg_shuffle_rng RTL.
module tb_combined_lcg_shuffle_rng;
  import clsr_pkg::*;

  // Kind flag carried on tuser
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned TAIL_ITEMS   = 200;      // no idling once this few remain
  // Worst case per item: reseed warm-up, the draw itself, both stall bursts
  localparam int unsigned DRAIN_CYCLES = WARM_STEPS * 3 + 6 + 2 * 18;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;

  typedef struct {
    logic             kind;
    logic [VAL_W-1:0] seed;
    bit               hold;   // wait for every result before offering this one
  } rng_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic        s_user  = KIND_DRAW;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  combined_lcg_shuffle_rng dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),    // [30:0] seed_value, [31] zero
    .s_axis_tuser_i  (s_user),    // [0] kind
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)  // [30:0] random_value, [31] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Generator model: its own copy of both generators, the output register and
  // the shuffle table, starting from the reset state.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] gen_a    = 31'd1;
  logic [VAL_W-1:0] gen_b    = SEED_B_RESET;
  logic [VAL_W-1:0] prev_out = '0;
  logic [VAL_W-1:0] shuffle_mem [TABLE_DEPTH];

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) shuffle_mem[i] = '0;
  end

  // Exact product, then reduce: same value as Schrage's method
  function automatic logic [VAL_W-1:0] lcg_advance(input logic [VAL_W-1:0] x,
                                                  input logic [MUL_W-1:0] mult,
                                                  input logic [VAL_W-1:0] modulus);
    logic [63:0] prod;
    prod = 64'(x) * 64'(mult);
    return VAL_W'(prod % 64'(modulus));
  endfunction

  function automatic logic [VAL_W-1:0] next_random(input logic kind,
                                                  input logic [VAL_W-1:0] seed);
    logic [VAL_W-1:0] start;
    int unsigned      slot;
    longint           mixed;
    if (kind == KIND_RESEED) begin
      // Zero seed becomes one; seeds at or above a modulus are taken as they are
      start = (seed == '0) ? 31'd1 : seed;
      gen_a = start;
      gen_b = start;
      // Warm up; the last TABLE_DEPTH steps fill the table from the top slot down
      for (int k = WARM_STEPS - 1; k >= 0; k--) begin
        gen_a = lcg_advance(gen_a, MUL_A, MOD_A);
        if (k < TABLE_DEPTH) shuffle_mem[k] = gen_a;
      end
      prev_out = shuffle_mem[0];
    end
    gen_a = lcg_advance(gen_a, MUL_A, MOD_A);
    gen_b = lcg_advance(gen_b, MUL_B, MOD_B);
    slot = int'(prev_out / SLOT_DIV);
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    mixed = longint'(shuffle_mem[slot]) - longint'(gen_b);
    shuffle_mem[slot] = gen_a;
    if (mixed < 1) mixed += longint'(SPAN);
    prev_out = VAL_W'(mixed);
    return prev_out;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue, counters shared between the processes
  // ---------------------------------------------------------------------------
  rng_req_t         req_q[$];
  logic [VAL_W-1:0] draw_expect_q[$];
  int unsigned      total_items = 0;
  int unsigned      acc_cnt     = 0;   // input transfers, updated with NBAs
  int unsigned      res_cnt     = 0;   // output transfers, updated with NBAs
  int unsigned      err_cnt     = 0;
  int unsigned      cycle_cnt   = 0;
  logic             quiet_tail  = 1'b0;

  function automatic void add_req(input logic kind, input logic [VAL_W-1:0] seed,
                                  input bit hold);
    rng_req_t r;
    r.kind = kind;
    r.seed = seed;
    r.hold = hold;
    req_q.push_back(r);
    total_items++;
  endfunction

  function automatic logic [VAL_W-1:0] pick_seed();
    case ($urandom_range(11))
      0:       return '0;
      1:       return 31'd1;
      2:       return MOD_A;
      3:       return MOD_B;
      4:       return '1;
      5:       return MOD_A - 31'd1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer queued items, hold valid until taken, idle in bursts
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned gap_pct  = 20;
  int unsigned sent_now = 0;

  always @(posedge clk_i) begin
    int unsigned in_flight;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!(s_valid && !s_axis_tready_o)) begin
      // Nothing offered, or the offered item is being taken at this edge
      in_flight = acc_cnt - res_cnt + ((s_valid && s_axis_tready_o) ? 1 : 0);
      quiet_tail <= (req_q.size() < TAIL_ITEMS);
      if (gap_left > 0 && !quiet_tail) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (req_q.size() == 0 || (req_q[0].hold && in_flight != 0)) begin
        s_valid <= 1'b0;
      end else begin
        s_valid <= 1'b1;
        s_user  <= req_q[0].kind;
        s_data  <= {1'b0, req_q[0].seed};
        void'(req_q.pop_front());
        sent_now++;
        // Change the idling density now and then, leaving stretches with none
        if (sent_now % 64 == 0) begin
          case ($urandom_range(2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 50;
          endcase
        end
        if ($urandom_range(99) < gap_pct) gap_left = $urandom_range(1, 18);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall tready in bursts, except in the tail of the run
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 10;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (quiet_tail) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (cycle_cnt % 256 == 0) begin
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      if ($urandom_range(99) < stall_pct) stall_left = $urandom_range(1, 18);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [VAL_W-1:0] want;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        draw_expect_q.push_back(next_random(s_user, s_data[VAL_W-1:0]));
        acc_cnt <= acc_cnt + 1;
      end
      if (m_axis_tvalid_o && m_ready) begin
        if (draw_expect_q.size() == 0) begin
          $error("random_value: no result expected, actual %0d", m_axis_tdata_o[VAL_W-1:0]);
          err_cnt++;
        end else begin
          want = draw_expect_q.pop_front();
          if (m_axis_tdata_o[VAL_W-1:0] !== want) begin
            $error("random_value: expected %0d, actual %0d", want,
                   m_axis_tdata_o[VAL_W-1:0]);
            err_cnt++;
          end
        end
        res_cnt <= res_cnt + 1;
      end
    end
  end

  // Drop out if the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Build the stimulus, release reset, wait for the run to drain
  // ---------------------------------------------------------------------------
  initial begin
    logic kind;
    // Draws straight from reset: slot zero holds zero, so the difference wraps
    add_req(KIND_DRAW, '0, 1'b0);
    add_req(KIND_DRAW, '1, 1'b0);
    add_req(KIND_DRAW, 31'h2AAA_AAAA, 1'b0);
    // Zero seed forced to one, then the smallest and largest seeds
    add_req(KIND_RESEED, '0, 1'b0);
    add_req(KIND_DRAW, 31'h5555_5555, 1'b0);
    add_req(KIND_RESEED, 31'd1, 1'b0);
    add_req(KIND_DRAW, '0, 1'b0);
    add_req(KIND_RESEED, '1, 1'b0);
    add_req(KIND_DRAW, '0, 1'b0);
    // Seed equal to the first modulus pins the first generator at zero
    add_req(KIND_RESEED, MOD_A, 1'b1);
    add_req(KIND_DRAW, '0, 1'b0);
    add_req(KIND_DRAW, '0, 1'b0);
    // Seed equal to the second modulus pins the second generator at zero
    add_req(KIND_RESEED, MOD_B, 1'b0);
    add_req(KIND_DRAW, '0, 1'b0);
    add_req(KIND_DRAW, '0, 1'b0);
    // Seeds just below each modulus, and back-to-back reseeds
    add_req(KIND_RESEED, MOD_A - 31'd1, 1'b0);
    add_req(KIND_RESEED, MOD_B - 31'd1, 1'b0);
    add_req(KIND_RESEED, 31'h2AAA_AAAA, 1'b0);
    add_req(KIND_DRAW, '1, 1'b1);
    add_req(KIND_RESEED, 31'h5555_5555, 1'b0);

    // Random part: mostly long draw runs, reseeds now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = ($urandom_range(99) < 8) ? KIND_RESEED : KIND_DRAW;
      add_req(kind, (kind == KIND_RESEED) ? pick_seed() : VAL_W'($urandom),
              ($urandom_range(199) == 0));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!(acc_cnt == total_items && res_cnt == acc_cnt));
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && draw_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
